/* hdl/mpk_pkg.sv */
// ----------------------------------------------------------------------------
// mpk_pkg
// Shared constants for the k-transaction best profit unit.
// ----------------------------------------------------------------------------
package mpk_pkg;

    localparam int PRICE_W   = 16;
    localparam int PROFIT_W  = 20;
    localparam int K_W       = 5;
    localparam int TDATA_IN  = 16;
    localparam int TDATA_OUT = 24;

    localparam logic [K_W-1:0]      K_RESET    = 5'd2;
    localparam logic [PROFIT_W-1:0] PROFIT_MAX = 20'hFFFFF;

endpackage

/* hdl/mpk_ram.sv */
// ----------------------------------------------------------------------------
// mpk_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module mpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hdl/max_profit_k_transactions_unit.sv */
// ----------------------------------------------------------------------------
// max_profit_k_transactions_unit
// Best profit with at most k buy-sell transactions over a price stream.
//
//  Channel   Dir  Fields (low bit first)            Handshake
//  s_axis    in   tdata: price[15:0]                tvalid/tready
//                 tuser: new_series
//  m_axis    out  tdata: best_profit[19:0], zeros   tvalid/tready
//  cfg       in   i_cfg_wdata: max_transactions     i_cfg_we, no wait
//
// Each item is swept through the state RAM one transaction entry at a time
// (read, update, write back), between its issue and its hand-off.
// Reset is synchronous; it clears the per-entry valid bits, so no RAM pass
// is needed. A new series clears the valid bits at once.
// A result waits in the output register; the next item is taken meanwhile,
// and only its hand-off stalls while the register is still full.
// ----------------------------------------------------------------------------
module max_profit_k_transactions_unit #(
    parameter int MAX_K = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mpk_pkg::TDATA_IN-1:0]   s_axis_tdata,   // price[15:0]
    input  logic                           s_axis_tuser,   // new_series
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mpk_pkg::TDATA_OUT-1:0]  m_axis_tdata,   // best_profit[19:0], zeros
    input  logic                           i_cfg_we,
    input  logic [mpk_pkg::K_W-1:0]        i_cfg_wdata     // max_transactions
);

    import mpk_pkg::*;

    localparam int IdxW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int FreeW = $clog2(MAX_K * 65535 + 1);
    localparam int HoldW = FreeW + 1;
    localparam int ExtW  = (FreeW > PROFIT_W) ? FreeW : PROFIT_W + 1;
    localparam int CmpW  = ($clog2(MAX_K + 1) > K_W) ? $clog2(MAX_K + 1) : K_W;
    localparam int RamW  = HoldW + FreeW;

    localparam logic [IdxW-1:0]  LastIdx    = IdxW'(MAX_K - 1);
    localparam logic [HoldW-1:0] NoPosition = HoldW'(-65536);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [IdxW-1:0]       r_idx, n_idx;
    logic [K_W-1:0]        r_k;
    logic [PRICE_W-1:0]    r_price, n_price;
    logic                  r_kzero, n_kzero;
    logic [IdxW-1:0]       r_ksel, n_ksel;
    logic [FreeW-1:0]      r_prev_free, n_prev_free;
    logic [FreeW-1:0]      r_best, n_best;
    logic [MAX_K-1:0]      r_valid, n_valid;
    logic                  r_out_valid, n_out_valid;
    logic [PROFIT_W-1:0]   r_out_data, n_out_data;

    logic                  w_accept;
    logic                  w_re;
    logic [IdxW-1:0]       w_raddr;
    logic [RamW-1:0]       w_rdata;
    logic [RamW-1:0]       w_wdata;
    logic                  w_we;
    logic [HoldW-1:0]      w_hold_old, w_hold_new, w_buy, w_sell;
    logic [FreeW-1:0]      w_free_old, w_free_new;
    logic [CmpW-1:0]       w_k_ext;
    logic [ExtW-1:0]       w_best_ext;

    mpk_ram #(
        .WIDTH (RamW),
        .DEPTH (MAX_K)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_OUT - PROFIT_W){1'b0}}, r_out_data};

    always_comb begin
        if (r_valid[r_idx]) begin
            w_hold_old = w_rdata[RamW-1:FreeW];
            w_free_old = w_rdata[FreeW-1:0];
        end else begin
            w_hold_old = NoPosition;
            w_free_old = '0;
        end
        w_buy      = HoldW'(r_prev_free) - HoldW'(r_price);
        w_hold_new = ($signed(w_buy) > $signed(w_hold_old)) ? w_buy : w_hold_old;
        w_sell     = w_hold_new + HoldW'(r_price);
        w_free_new = ($signed(w_sell) > $signed(HoldW'(w_free_old)))
                     ? w_sell[FreeW-1:0] : w_free_old;
        w_wdata    = {w_hold_new, w_free_new};
        w_we       = (r_state == ST_SWEEP);
        w_k_ext    = CmpW'(r_k);
        w_best_ext = ExtW'(r_best);
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = '0;
        if (w_accept) begin
            w_re = 1'b1;
        end else if (r_state == ST_SWEEP && r_idx != LastIdx) begin
            w_re    = 1'b1;
            w_raddr = r_idx + 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_price     = r_price;
        n_kzero     = r_kzero;
        n_ksel      = r_ksel;
        n_prev_free = r_prev_free;
        n_best      = r_best;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state     = ST_SWEEP;
                    n_idx       = '0;
                    n_price     = s_axis_tdata[PRICE_W-1:0];
                    n_prev_free = '0;
                    n_best      = '0;
                    n_kzero     = (r_k == '0);
                    if (w_k_ext > CmpW'(MAX_K)) begin
                        n_ksel = LastIdx;
                    end else begin
                        n_ksel = IdxW'(w_k_ext - 1'b1);
                    end
                    if (s_axis_tuser) begin
                        n_valid = '0;
                    end
                end
            end
            ST_SWEEP: begin
                n_valid[r_idx] = 1'b1;
                n_prev_free    = w_free_new;
                if (!r_kzero && r_idx == r_ksel) begin
                    n_best = w_free_new;
                end
                if (r_idx == LastIdx) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (w_best_ext > ExtW'(PROFIT_MAX))
                                  ? PROFIT_MAX : w_best_ext[PROFIT_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= K_RESET;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_price     <= n_price;
        r_kzero     <= n_kzero;
        r_ksel      <= n_ksel;
        r_prev_free <= n_prev_free;
        r_best      <= n_best;
        r_out_data  <= n_out_data;
    end

    a_accept_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SWEEP) && (r_idx == '0))
        else $error("accepted item did not start a sweep at entry zero");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) && (r_idx == LastIdx) |=> (r_state == ST_DONE))
        else $error("sweep did not finish after the last entry");

    a_done_hands_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && (!r_out_valid || m_axis_tready)
        |=> m_axis_tvalid && (r_state == ST_IDLE))
        else $error("finished result was not loaded into the output register");

    a_entry_written_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |=> r_valid[$past(r_idx)])
        else $error("swept entry was not marked valid");

endmodule

/* sim/mpk_profit_checker.sv */
// ----------------------------------------------------------------------------
// mpk_profit_checker
// Watches the price and profit channels and the register port of the
// k-transaction best profit unit. It keeps its own copy of the per-count
// holding and free values, predicts the profit for every accepted price,
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module mpk_profit_checker #(
    parameter int MAX_K = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [mpk_pkg::TDATA_IN-1:0]   i_s_tdata,    // price[15:0]
    input  logic                           i_s_tuser,    // new_series
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [mpk_pkg::TDATA_OUT-1:0]  i_m_tdata,    // best_profit[19:0], zeros
    input  logic                           i_cfg_we,
    input  logic [mpk_pkg::K_W-1:0]        i_cfg_wdata,  // max_transactions
    output int                             o_fails,
    output int                             o_pending
);
    import mpk_pkg::*;

    logic signed [21:0]   hold_val [MAX_K];
    logic        [20:0]   free_val [MAX_K];
    logic [K_W-1:0]       tx_limit;
    logic [PROFIT_W-1:0]  expected_profit [$];
    int                   fail_count;

    function automatic void clear_series();
        for (int j = 0; j < MAX_K; j++) begin
            hold_val[j] = -22'sd65536;
            free_val[j] = '0;
        end
    endfunction

    function automatic logic [PROFIT_W-1:0] next_best_profit(
        input logic [PRICE_W-1:0] price,
        input logic               fresh
    );
        int carry_free;
        int buy;
        int sell;
        int best;
        int k_eff;
        if (fresh) begin
            clear_series();
        end
        carry_free = 0;
        for (int j = 0; j < MAX_K; j++) begin
            buy = carry_free - int'(price);
            if (buy > int'(hold_val[j])) begin
                hold_val[j] = buy[21:0];
            end
            sell = int'(hold_val[j]) + int'(price);
            if (sell > int'(free_val[j])) begin
                free_val[j] = sell[20:0];
            end
            carry_free = int'(free_val[j]);
        end
        k_eff = (int'(tx_limit) > MAX_K) ? MAX_K : int'(tx_limit);
        best = (k_eff == 0) ? 0 : int'(free_val[k_eff-1]);
        if (best < 0) begin
            best = 0;
        end
        if (best > int'(PROFIT_MAX)) begin
            best = int'(PROFIT_MAX);
        end
        return best[PROFIT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ERROR %s: got %0d, wanted %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        logic [PROFIT_W-1:0] want_profit;
        if (!i_rst_n) begin
            clear_series();
            tx_limit = K_RESET;
            expected_profit.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                tx_limit = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_profit.size() == 0) begin
                    report_mismatch("profit item with none pending",
                                    int'(i_m_tdata[PROFIT_W-1:0]), 0);
                end else begin
                    want_profit = expected_profit.pop_front();
                    if (i_m_tdata[PROFIT_W-1:0] != want_profit) begin
                        report_mismatch("best_profit", int'(i_m_tdata[PROFIT_W-1:0]),
                                        int'(want_profit));
                    end
                    if (i_m_tdata[TDATA_OUT-1:PROFIT_W] != '0) begin
                        report_mismatch("tdata padding",
                                        int'(i_m_tdata[TDATA_OUT-1:PROFIT_W]), 0);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_profit.push_back(next_best_profit(i_s_tdata[PRICE_W-1:0],
                                                           i_s_tuser));
            end
        end
        o_fails   <= fail_count;
        o_pending <= expected_profit.size();
    end

endmodule

/* sim/tb_max_profit_k_transactions_unit.sv */
// ----------------------------------------------------------------------------
// tb_max_profit_k_transactions_unit
// Drives price items into the k-transaction best profit unit with random
// gaps and output stalls, and changes the transaction limit between runs.
// A short directed part covers the price extremes, a zero limit, limits
// above the entry count and a limit change within one series. Random runs
// follow, built mostly from shaped price series with random content.
// ----------------------------------------------------------------------------
module tb_max_profit_k_transactions_unit;
    import mpk_pkg::*;

    localparam int MAX_K        = 16;
    localparam int RANDOM_ITEMS = 1430;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4 * (MAX_K + 2);

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_ZIGZAG,
        SHAPE_WALK,
        SHAPE_FALLING
    } t_price_shape;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_IN-1:0]   s_axis_tdata;   // price[15:0]
    logic                  s_axis_tuser;   // new_series
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_OUT-1:0]  m_axis_tdata;   // best_profit[19:0], zeros
    logic                  i_cfg_we;
    logic [K_W-1:0]        i_cfg_wdata;    // max_transactions

    int                    fails;
    int                    pending;
    int                    idle_cycles;
    bit                    src_burst;
    bit                    sink_burst;

    max_profit_k_transactions_unit #(.MAX_K(MAX_K)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    mpk_profit_checker #(.MAX_K(MAX_K)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fails     (fails),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_price(input logic [PRICE_W-1:0] price, input logic fresh);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= price;
        s_axis_tuser  <= fresh;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_tx_limit(input logic [K_W-1:0] limit);
        i_cfg_wdata <= limit;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int           sent;
        int           run_len;
        int           cur;
        bit           fresh;
        bit           zig;
        t_price_shape shape;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        src_burst     = 1'b0;
        sink_burst    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset limit of two transactions caps the alternating extremes.
        send_price(16'd0, 1'b1);
        send_price(16'hFFFF, 1'b0);
        send_price(16'd0, 1'b0);
        send_price(16'hFFFF, 1'b0);
        send_price(16'd0, 1'b0);
        send_price(16'hFFFF, 1'b0);
        send_price(16'hFFFF, 1'b1);
        send_price(16'd30000, 1'b0);
        send_price(16'd0, 1'b0);
        settle();

        write_tx_limit(5'd0);
        send_price(16'd0, 1'b1);
        send_price(16'hFFFF, 1'b0);
        settle();

        write_tx_limit(5'd31);
        send_price(16'd100, 1'b1);
        send_price(16'hFFFF, 1'b0);
        send_price(16'd0, 1'b0);
        send_price(16'hFFFF, 1'b0);
        settle();

        // A smaller limit must answer for the series already under way.
        write_tx_limit(5'd1);
        send_price(16'hFFFF, 1'b0);
        settle();

        write_tx_limit(5'd17);
        send_price(16'd0, 1'b0);
        settle();

        write_tx_limit(5'd16);
        send_price(16'hFFFF, 1'b0);
        settle();

        sent  = 0;
        cur   = 32768;
        zig   = 1'b0;
        shape = SHAPE_ZIGZAG;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                write_tx_limit(5'd16);
            end else begin
                write_tx_limit(K_W'($urandom_range(0, 31)));
            end
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            run_len    = $urandom_range(10, 120);
            for (int n = 0; n < run_len; n++) begin
                fresh = ($urandom_range(0, 39) == 0);
                if (fresh) begin
                    shape = t_price_shape'($urandom_range(0, 3));
                end
                if ($urandom_range(0, 19) == 0) begin
                    cur = $urandom_range(0, 65535);
                end else begin
                    case (shape)
                        SHAPE_UNIFORM: begin
                            cur = $urandom_range(0, 65535);
                        end
                        SHAPE_ZIGZAG: begin
                            zig = ~zig;
                            cur = zig ? $urandom_range(49152, 65535) : $urandom_range(0, 16383);
                        end
                        SHAPE_WALK: begin
                            cur = cur + int'($urandom_range(0, 8190)) - 4095;
                        end
                        default: begin
                            cur = cur - int'($urandom_range(0, 2000));
                        end
                    endcase
                    if (cur < 0) begin
                        cur = 0;
                    end else if (cur > 65535) begin
                        cur = 65535;
                    end
                end
                send_price(cur[PRICE_W-1:0], fresh);
            end
            sent += run_len;
            settle();
        end

        src_burst  = 1'b0;
        sink_burst = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
